// ===== rtl/core/fatcp_pkg.sv =====
// Shared types and constants of the FAT12 chain page classifier.
`default_nettype none
package fatcp_pkg;

   localparam logic [1:0] OP_FAT_WR = 2'd0;
   localparam logic [1:0] OP_CHAIN  = 2'd1;
   localparam logic [1:0] OP_REGION = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [2:0] REG_SECTOR_SHIFT    = 3'd0;
   localparam logic [2:0] REG_PAGE_SHIFT      = 3'd1;
   localparam logic [2:0] REG_DATA_START      = 3'd2;
   localparam logic [2:0] REG_CLUSTER_COUNT   = 3'd3;
   localparam logic [2:0] REG_FAT_LENGTH      = 3'd4;
   localparam logic [2:0] REG_LOGICAL_SECTORS = 3'd5;

   localparam logic [2:0] PG_META          = 3'd1;
   localparam logic [2:0] PG_LIVE          = 3'd3;
   localparam logic [2:0] PG_SLACK         = 3'd5;
   localparam logic [2:0] CLS_FREE_PENDING = 3'd7;

   localparam logic [1:0] PSEL_LIVE   = 2'd0;
   localparam logic [1:0] PSEL_CSLACK = 2'd1;
   localparam logic [1:0] PSEL_META   = 2'd2;
   localparam logic [1:0] PSEL_RSLACK = 2'd3;

   localparam logic [11:0] MAX_CLUSTERS = 12'd2728;
   localparam logic [11:0] FAT12_END    = 12'hFF8;
   localparam logic [11:0] FAT12_MASK   = 12'hFFF;

   localparam int ADDR_W = 26;

   typedef struct packed {
      logic       load;
      logic       clr_step;
      logic       fat_wr;
      logic       cap_page;
      logic       calc;
      logic       paint_load;
      logic [1:0] paint_sel;
      logic       paint_step;
      logic       inc_i;
      logic       fat_rd_hi;
      logic       cap_lo;
      logic       adv;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic walk_ok;
      logic paint_more;
      logic fat_in;
      logic next_cont;
   } ctrl_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/fatcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fatcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/fatcp_ctrl.sv =====
// Controller state machine of the FAT12 chain page classifier.
`default_nettype none
module fatcp_ctrl
   import fatcp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [1:0]      op,
   input  wire ctrl_status_type st,
   output ctrl_cmd_type         cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CLEAR  = 5'd1;
   localparam logic [4:0] S_FATWR  = 5'd2;
   localparam logic [4:0] S_RDWAIT = 5'd3;
   localparam logic [4:0] S_RDCAP  = 5'd4;
   localparam logic [4:0] S_WCHECK = 5'd5;
   localparam logic [4:0] S_WCALC  = 5'd6;
   localparam logic [4:0] S_LDLIVE = 5'd7;
   localparam logic [4:0] S_PLIVE  = 5'd8;
   localparam logic [4:0] S_LDCS   = 5'd9;
   localparam logic [4:0] S_PCS    = 5'd10;
   localparam logic [4:0] S_ENTRY  = 5'd11;
   localparam logic [4:0] S_FAT0   = 5'd12;
   localparam logic [4:0] S_FAT1   = 5'd13;
   localparam logic [4:0] S_FAT2   = 5'd14;
   localparam logic [4:0] S_LDMETA = 5'd15;
   localparam logic [4:0] S_PMETA  = 5'd16;
   localparam logic [4:0] S_LDRS   = 5'd17;
   localparam logic [4:0] S_PRS    = 5'd18;
   localparam logic [4:0] S_RESP   = 5'd19;

   logic [4:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (op)
                  OP_FAT_WR: state_in = S_FATWR;
                  OP_CHAIN:  state_in = S_WCHECK;
                  OP_REGION: state_in = S_LDMETA;
                  default:   state_in = S_RDWAIT;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_FATWR: begin
            cmd.fat_wr = 1'b1;
            state_in = S_RESP;
         end
         S_RDWAIT: state_in = S_RDCAP;
         S_RDCAP: begin
            cmd.cap_page = 1'b1;
            state_in = S_RESP;
         end
         S_WCHECK: state_in = st.walk_ok ? S_WCALC : S_RESP;
         S_WCALC: begin
            cmd.calc = 1'b1;
            state_in = S_LDLIVE;
         end
         S_LDLIVE: begin
            cmd.paint_load = 1'b1;
            cmd.paint_sel = PSEL_LIVE;
            state_in = S_PLIVE;
         end
         S_PLIVE: begin
            if (st.paint_more) cmd.paint_step = 1'b1;
            else state_in = S_LDCS;
         end
         S_LDCS: begin
            cmd.paint_load = 1'b1;
            cmd.paint_sel = PSEL_CSLACK;
            state_in = S_PCS;
         end
         S_PCS: begin
            if (st.paint_more) cmd.paint_step = 1'b1;
            else state_in = S_ENTRY;
         end
         S_ENTRY: begin
            cmd.inc_i = 1'b1;
            state_in = st.fat_in ? S_FAT0 : S_RESP;
         end
         S_FAT0: state_in = S_FAT1;
         S_FAT1: begin
            cmd.fat_rd_hi = 1'b1;
            cmd.cap_lo = 1'b1;
            state_in = S_FAT2;
         end
         S_FAT2: begin
            cmd.adv = 1'b1;
            state_in = st.next_cont ? S_WCHECK : S_RESP;
         end
         S_LDMETA: begin
            cmd.paint_load = 1'b1;
            cmd.paint_sel = PSEL_META;
            state_in = S_PMETA;
         end
         S_PMETA: begin
            if (st.paint_more) cmd.paint_step = 1'b1;
            else state_in = S_LDRS;
         end
         S_LDRS: begin
            cmd.paint_load = 1'b1;
            cmd.paint_sel = PSEL_RSLACK;
            state_in = S_PRS;
         end
         S_PRS: begin
            if (st.paint_more) cmd.paint_step = 1'b1;
            else state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   a_resp_pulse: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> (state_ff == S_IDLE))
      else $error("response not a single-cycle pulse");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> (state_ff != S_IDLE))
      else $error("accepted command left controller idle");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLEAR))
      else $error("reset did not start clearing pass");

   a_paint_in_paint_state: assert property (@(posedge clock) disable iff (reset)
      cmd.paint_step |-> (state_ff == S_PLIVE || state_ff == S_PCS ||
                          state_ff == S_PMETA || state_ff == S_PRS))
      else $error("page write outside a paint state");

endmodule
`default_nettype wire

// ===== rtl/core/fatcp_dp.sv =====
// Datapath of the FAT12 chain page classifier: registers, FAT copy and page map.
`default_nettype none
module fatcp_dp
   import fatcp_pkg::*;
#(
   parameter int FAT_BYTES = 4096,
   parameter int MAP_PAGES = 4096
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ctrl_cmd_type    cmd,
   output ctrl_status_type      st,
   input  wire logic            csr_wr,
   input  wire logic [2:0]      csr_index,
   input  wire logic [12:0]     csr_wdata,
   input  wire logic [11:0]     req_fat_index,
   input  wire logic [7:0]      req_fat_byte,
   input  wire logic [15:0]     req_start_cluster,
   input  wire logic [31:0]     req_file_size,
   input  wire logic [23:0]     req_region_start,
   input  wire logic [23:0]     req_region_used,
   input  wire logic [23:0]     req_region_length,
   input  wire logic [11:0]     req_page_index,
   output logic      [2:0]      rsp_page_class,
   output logic      [11:0]     rsp_clusters_walked
);

   localparam int FAT_AW  = $clog2(FAT_BYTES);
   localparam int PAGE_AW = $clog2(MAP_PAGES);

   logic [3:0]  sshift_ff, pshift_ff;
   logic [7:0]  dstart_ff;
   logic [11:0] ccount_ff;
   logic [12:0] flen_ff;
   logic [8:0]  lsec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sshift_ff <= 4'd12;
         pshift_ff <= 4'd8;
         dstart_ff <= 8'd0;
         ccount_ff <= 12'd0;
         flen_ff   <= 13'd4096;
         lsec_ff   <= 9'd0;
      end else if (csr_wr) begin
         case (csr_index)
            REG_SECTOR_SHIFT:    sshift_ff <= csr_wdata[3:0];
            REG_PAGE_SHIFT:      pshift_ff <= csr_wdata[3:0];
            REG_DATA_START:      dstart_ff <= csr_wdata[7:0];
            REG_CLUSTER_COUNT:   ccount_ff <= csr_wdata[11:0];
            REG_FAT_LENGTH:      flen_ff   <= csr_wdata;
            REG_LOGICAL_SECTORS: lsec_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic [3:0]        ss, ps;
   logic [11:0]       n_eff;
   logic [31:0]       len_eff;
   logic [ADDR_W-1:0] limit, secsz, pgsz, pmask;

   always_comb begin
      if (sshift_ff < 4'd9) ss = 4'd9;
      else if (sshift_ff > 4'd12) ss = 4'd12;
      else ss = sshift_ff;
      if (pshift_ff < 4'd4) ps = 4'd4;
      else if (pshift_ff > ss) ps = ss;
      else ps = pshift_ff;
      n_eff = (ccount_ff > MAX_CLUSTERS) ? MAX_CLUSTERS : ccount_ff;
      len_eff = (32'(flen_ff) < 32'(FAT_BYTES)) ? 32'(flen_ff) : 32'(FAT_BYTES);
      limit = ADDR_W'(lsec_ff) << ss;
      secsz = ADDR_W'(1) << ss;
      pgsz  = ADDR_W'(1) << ps;
      pmask = pgsz - ADDR_W'(1);
   end

   logic [11:0]       fidx_ff;
   logic [7:0]        fbyte_ff;
   logic [15:0]       c_ff, c_in;
   logic [31:0]       size_ff;
   logic [ADDR_W-1:0] rstart_ff, rused_ff, rlen_ff;
   logic [11:0]       pg_ff, i_ff;
   logic [2:0]        cls_ff;
   logic [ADDR_W-1:0] base_ff, live_ff, a_ff, end_ff, a_in, end_in;
   logic [2:0]        pcls_ff, pcls_in;
   logic [PAGE_AW-1:0] clr_ff;
   logic [7:0]        lo_ff;

   logic [31:0]       done_w, rem_w;
   logic [ADDR_W-1:0] cov_w, base_w, live_w;
   logic [ADDR_W-1:0] b0, b1, aligned;
   logic              pok;
   logic [12:0]       ofs;
   logic [15:0]       fat_v;
   logic [11:0]       next_w;
   logic [7:0]        fat_rdata;
   logic [2:0]        page_rdata;
   logic [31:0]       pg_wide, pa_wide, fw_wide, fr_wide;
   logic [FAT_AW-1:0] fat_wr_addr, fat_rd_addr;
   logic [PAGE_AW-1:0] page_wr_addr, page_rd_addr;
   logic              page_we;
   logic [2:0]        page_wdata;

   always_comb begin
      done_w = 32'(i_ff) << ss;
      rem_w = (size_ff > done_w) ? (size_ff - done_w) : 32'd0;
      cov_w = (rem_w > 32'(secsz)) ? secsz : ADDR_W'(rem_w);
      live_w = (cov_w + pmask) & ~pmask;
      base_w = (ADDR_W'(dstart_ff) + ADDR_W'(c_ff) - ADDR_W'(2)) << ss;
      aligned = rstart_ff + ((rused_ff + pmask) & ~pmask);
      pok = 1'b1;
      case (cmd.paint_sel)
         PSEL_LIVE: begin
            b0 = base_ff;
            b1 = base_ff + live_ff;
            pcls_in = PG_LIVE;
         end
         PSEL_CSLACK: begin
            b0 = base_ff + live_ff;
            b1 = base_ff + secsz;
            pcls_in = PG_SLACK;
         end
         PSEL_META: begin
            b0 = rstart_ff;
            b1 = rstart_ff + rused_ff;
            pcls_in = PG_META;
         end
         default: begin
            b0 = aligned;
            b1 = rstart_ff + rlen_ff;
            pcls_in = PG_SLACK;
            pok = (aligned < b1);
         end
      endcase
      a_in = b0 & ~pmask;
      end_in = pok ? ((b1 < limit) ? b1 : limit) : '0;
      ofs = 13'(c_ff[11:0]) + 13'(c_ff[11:1]);
      fat_v = {fat_rdata, lo_ff};
      next_w = c_ff[0] ? fat_v[15:4] : (fat_v[11:0] & FAT12_MASK);
      c_in = {4'd0, next_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + PAGE_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fidx_ff   <= req_fat_index;
         fbyte_ff  <= req_fat_byte;
         c_ff      <= req_start_cluster;
         size_ff   <= req_file_size;
         rstart_ff <= ADDR_W'(req_region_start);
         rused_ff  <= (req_region_used > req_region_length) ?
                      ADDR_W'(req_region_length) : ADDR_W'(req_region_used);
         rlen_ff   <= ADDR_W'(req_region_length);
         pg_ff     <= req_page_index;
         i_ff      <= 12'd0;
         cls_ff    <= 3'd0;
      end else begin
         if (cmd.cap_page) begin
            cls_ff <= (32'(pg_ff) < 32'(MAP_PAGES)) ? page_rdata : CLS_FREE_PENDING;
         end
         if (cmd.inc_i) i_ff <= i_ff + 12'd1;
         if (cmd.adv) c_ff <= c_in;
      end
      if (cmd.calc) begin
         base_ff <= base_w;
         live_ff <= live_w;
      end
      if (cmd.paint_load) begin
         a_ff    <= a_in;
         end_ff  <= end_in;
         pcls_ff <= pcls_in;
      end else if (cmd.paint_step) begin
         a_ff <= a_ff + pgsz;
      end
      if (cmd.cap_lo) lo_ff <= fat_rdata;
   end

   always_comb begin
      fw_wide = 32'(fidx_ff);
      fr_wide = 32'(ofs) + (cmd.fat_rd_hi ? 32'd1 : 32'd0);
      fat_wr_addr = fw_wide[FAT_AW-1:0];
      fat_rd_addr = fr_wide[FAT_AW-1:0];
      pg_wide = 32'(pg_ff);
      pa_wide = 32'(a_ff >> ps);
      page_rd_addr = pg_wide[PAGE_AW-1:0];
      if (cmd.clr_step) begin
         page_we = 1'b1;
         page_wr_addr = clr_ff;
         page_wdata = CLS_FREE_PENDING;
      end else begin
         page_we = cmd.paint_step;
         page_wr_addr = pa_wide[PAGE_AW-1:0];
         page_wdata = pcls_ff;
      end
   end

   fatcp_ram #(.WIDTH(8), .DEPTH(FAT_BYTES)) u_fat (
      .clock   (clock),
      .wr_en   (cmd.fat_wr && (32'(fidx_ff) < 32'(FAT_BYTES))),
      .wr_addr (fat_wr_addr),
      .wr_data (fbyte_ff),
      .rd_addr (fat_rd_addr),
      .rd_data (fat_rdata)
   );

   fatcp_ram #(.WIDTH(3), .DEPTH(MAP_PAGES)) u_map (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (page_wr_addr),
      .wr_data (page_wdata),
      .rd_addr (page_rd_addr),
      .rd_data (page_rdata)
   );

   always_comb begin
      st.clr_last   = (clr_ff == PAGE_AW'(MAP_PAGES - 1));
      st.walk_ok    = (c_ff >= 16'd2) && (17'(c_ff) < (17'(n_eff) + 17'd2)) &&
                      (i_ff <= n_eff);
      st.paint_more = (a_ff < end_ff) && (32'(a_ff >> ps) < 32'(MAP_PAGES));
      st.fat_in     = (32'(ofs) + 32'd1 < len_eff);
      st.next_cont  = (next_w >= 12'd2) && (next_w < FAT12_END);
   end

   assign rsp_page_class = cls_ff;
   assign rsp_clusters_walked = i_ff;

   a_paint_in_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.paint_step |-> (a_ff < limit))
      else $error("page written beyond logical size");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.inc_i |-> (i_ff <= n_eff))
      else $error("chain walk exceeded cluster bound");

   a_clear_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.clr_step && st.clr_last) |=> (clr_ff == '0))
      else $error("clearing counter did not wrap");

endmodule
`default_nettype wire

// ===== rtl/core/fat12_chain_page_classifier.sv =====
// Top level of the FAT12 chain page classifier.
// After reset the block sweeps the page map to free-pending, one page a cycle,
// with busy high; configuration writes are taken throughout.
// A command is taken when start is high and busy low, and its result shows on
// the rsp_ ports for one cycle with rsp_valid; the receiver cannot hold it off.
// A region mark paints its pages one at a time through the single write port of
// the page map. A chain walk paints, per cluster, each page of that cluster (up to
// sector size over page size) through the same port and reads two FAT bytes per
// link.
`default_nettype none
module fat12_chain_page_classifier
   import fatcp_pkg::*;
#(
   parameter int FAT_BYTES = 4096,
   parameter int MAP_PAGES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [11:0] req_fat_index,
   input  wire logic [7:0]  req_fat_byte,
   input  wire logic [15:0] req_start_cluster,
   input  wire logic [31:0] req_file_size,
   input  wire logic [23:0] req_region_start,
   input  wire logic [23:0] req_region_used,
   input  wire logic [23:0] req_region_length,
   input  wire logic [11:0] req_page_index,
   output logic             rsp_valid,
   output logic [2:0]       rsp_page_class,
   output logic [11:0]      rsp_clusters_walked,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type st;

   assign csr_ready = 1'b1;

   fatcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_operation),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fatcp_dp #(.FAT_BYTES(FAT_BYTES), .MAP_PAGES(MAP_PAGES)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .csr_wr              (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_fat_index       (req_fat_index),
      .req_fat_byte        (req_fat_byte),
      .req_start_cluster   (req_start_cluster),
      .req_file_size       (req_file_size),
      .req_region_start    (req_region_start),
      .req_region_used     (req_region_used),
      .req_region_length   (req_region_length),
      .req_page_index      (req_page_index),
      .rsp_page_class      (rsp_page_class),
      .rsp_clusters_walked (rsp_clusters_walked)
   );

endmodule
`default_nettype wire
